>>> design/rotm_pkg.sv
// shared types, constants and tap tables for the reverb output tap mixer
`timescale 1ns / 1ps

package rotm_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int ACC_W      = 28;
	localparam int RECIP_W    = 17;
	localparam int WEIGHT_W   = 4;
	localparam int MAX_LINES  = 16;
	localparam int POS_W      = $clog2(MAX_LINES);
	localparam int CNT_W      = POS_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int PROD_W     = ACC_W + RECIP_W + 1;
	localparam int FRAC_W     = 16;

	typedef enum logic [1:0] {
		PAT_WIDE     = 2'd0,
		PAT_CENTERED = 2'd1,
		PAT_AIRY     = 2'd2,
		PAT_SPLIT    = 2'd3
	} pattern_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_COUNT = 1'b0,
		CFG_PATTERN    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] left;
		logic signed [WEIGHT_W-1:0] right;
	} weights_t;

	localparam logic [RECIP_W-1:0] RECIP_WIDE     = 17'd9362;
	localparam logic [RECIP_W-1:0] RECIP_CENTERED = 17'd10923;
	localparam logic [RECIP_W-1:0] RECIP_AIRY     = 17'd16384;

	// reciprocal of the even-line count, indexed by count minus one
	localparam logic [RECIP_W-1:0] SPLIT_RECIP [8] = '{
		17'd65536, 17'd32768, 17'd21845, 17'd16384,
		17'd13107, 17'd10923, 17'd9362,  17'd8192
	};

	localparam logic [POS_W-1:0] P0_LEFT  [7] = '{4'd0, 4'd2, 4'd5, 4'd7, 4'd9, 4'd12, 4'd14};
	localparam logic [POS_W-1:0] P0_RIGHT [7] = '{4'd1, 4'd3, 4'd4, 4'd6, 4'd10, 4'd13, 4'd15};
	localparam logic [POS_W-1:0] P1_TAPS  [6] = '{4'd0, 4'd3, 4'd5, 4'd8, 4'd11, 4'd13};
	localparam logic [POS_W-1:0] P2_LEFT  [4] = '{4'd2, 4'd6, 4'd9, 4'd12};
	localparam logic [POS_W-1:0] P2_RIGHT [4] = '{4'd1, 4'd7, 4'd10, 4'd15};

	// wrapped tap index, indexed by [line count minus one][tap]
	typedef logic [MAX_LINES-1:0][MAX_LINES-1:0][POS_W-1:0] wrap_tbl_t;

	function automatic wrap_tbl_t build_wrap_tbl();
		wrap_tbl_t tbl;
		int v;
		tbl = '0;
		for (int m = 0; m < MAX_LINES; m++) begin
			for (int t = 0; t < MAX_LINES; t++) begin
				v = t;
				for (int k = 0; k < MAX_LINES; k++) begin
					if (v > m) begin
						v = v - (m + 1);
					end
				end
				tbl[m][t] = POS_W'(v);
			end
		end
		return tbl;
	endfunction

	localparam wrap_tbl_t WRAP_TBL = build_wrap_tbl();

	function automatic logic tap_hit(logic [POS_W-1:0] lines_m1, logic [POS_W-1:0] tap,
			logic [POS_W-1:0] pos);
		return WRAP_TBL[lines_m1][tap] == pos;
	endfunction

	function automatic weights_t tap_weights(pattern_t pattern, logic [POS_W-1:0] lines_m1,
			logic [POS_W-1:0] pos);
		weights_t w;
		w.left  = '0;
		w.right = '0;
		case (pattern)
			PAT_WIDE: begin
				for (int t = 0; t < 7; t++) begin
					if (tap_hit(lines_m1, P0_LEFT[t], pos)) begin
						w.left = (t % 2 == 1) ? w.left - 4'sd1 : w.left + 4'sd1;
					end
					if (tap_hit(lines_m1, P0_RIGHT[t], pos)) begin
						w.right = (t % 2 == 1) ? w.right + 4'sd1 : w.right - 4'sd1;
					end
				end
			end
			PAT_CENTERED: begin
				for (int t = 0; t < 6; t++) begin
					if (tap_hit(lines_m1, P1_TAPS[t], pos)) begin
						w.left = (t % 2 == 1) ? w.left - 4'sd1 : w.left + 4'sd1;
					end
				end
				w.right = -w.left;
			end
			PAT_AIRY: begin
				for (int t = 0; t < 4; t++) begin
					if (tap_hit(lines_m1, P2_LEFT[t], pos)) begin
						w.left = (t % 2 == 1) ? w.left - 4'sd1 : w.left + 4'sd1;
					end
					if (tap_hit(lines_m1, P2_RIGHT[t], pos)) begin
						w.right = (t % 2 == 1) ? w.right + 4'sd1 : w.right - 4'sd1;
					end
				end
			end
			PAT_SPLIT: begin
				w.left  = pos[0] ? 4'sd0 : 4'sd1;
				w.right = pos[0] ? 4'sd1 : 4'sd0;
			end
			default: begin
				w.left  = '0;
				w.right = '0;
			end
		endcase
		return w;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_for(pattern_t pattern,
			logic [POS_W-1:0] lines_m1);
		logic [RECIP_W-1:0] r;
		case (pattern)
			PAT_WIDE:     r = RECIP_WIDE;
			PAT_CENTERED: r = RECIP_CENTERED;
			PAT_AIRY:     r = RECIP_AIRY;
			PAT_SPLIT:    r = SPLIT_RECIP[lines_m1[POS_W-1:1]];
			default:      r = RECIP_WIDE;
		endcase
		return r;
	endfunction

endpackage

>>> design/reverb_output_tap_mixer_core.sv
// top level of the reverb output tap mixer: tap weighting, accumulation and result handoff
`timescale 1ns / 1ps

// One delay-line sample is taken per clock unless in_stall is high, line 0 first, up to
// line_count - 1. Each sample is weighted for left and right by the selected tap pattern and
// summed into two accumulators; after the last line of a frame one stereo result, scaled by the
// pattern's reciprocal tap count, floored and saturated, is formed from the sample register and
// carried through the frame, product and output registers in turn. The single input port feeds
// one multiply-accumulate per cycle while the input is not stalled; three result slots (frame,
// product and output registers) let samples keep flowing while a result waits. Write line_count
// or pattern_select only with no frame under way: a write restarts the frame at line 0.
module reverb_output_tap_mixer_core
	import rotm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [SAMPLE_W-1:0]   line_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [SAMPLE_W-1:0]   wet_left,
	output logic signed [SAMPLE_W-1:0]   wet_right
);

	logic [CNT_W-1:0]           line_count_q;
	pattern_t                   pattern_q;
	logic [POS_W-1:0]           pos_q;
	logic [POS_W-1:0]           lines_m1;
	logic signed [ACC_W-1:0]    acc_l_q;
	logic signed [ACC_W-1:0]    acc_r_q;
	logic                       s1_v_q;
	logic signed [SAMPLE_W-1:0] sample_s1;
	weights_t                   weights_s1;
	logic                       last_s1;
	logic [RECIP_W-1:0]         recip_s1;
	logic                       frame_v_s2;
	logic signed [ACC_W-1:0]    frame_l_s2;
	logic signed [ACC_W-1:0]    frame_r_s2;
	logic [RECIP_W-1:0]         recip_s2;
	weights_t                   weights;
	logic                       in_last;
	logic                       in_acc;
	logic                       s1_go;
	logic                       s1_free;
	logic                       frame_free;
	logic                       frame_take;
	logic signed [ACC_W-1:0]    sum_l;
	logic signed [ACC_W-1:0]    sum_r;

	// effective line count minus one, out-of-range counts clamped
	always_comb begin
		if (line_count_q == '0) begin
			lines_m1 = '0;
		end else if (line_count_q > CNT_W'(MAX_LINES)) begin
			lines_m1 = POS_W'(MAX_LINES - 1);
		end else begin
			lines_m1 = POS_W'(line_count_q - CNT_W'(1));
		end
	end

	assign weights = tap_weights(pattern_q, lines_m1, pos_q);
	assign in_last = pos_q >= lines_m1;

	assign frame_free = !frame_v_s2 || frame_take;
	assign s1_go      = s1_v_q && (!last_s1 || frame_free);
	assign s1_free    = !s1_v_q || s1_go;
	assign in_stall   = !s1_free;
	assign in_acc     = in_valid && s1_free;

	assign sum_l = acc_l_q + weights_s1.left * sample_s1;
	assign sum_r = acc_r_q + weights_s1.right * sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= CNT_W'(MAX_LINES);
			pattern_q    <= PAT_WIDE;
			pos_q        <= '0;
			acc_l_q      <= '0;
			acc_r_q      <= '0;
			s1_v_q       <= 1'b0;
			frame_v_s2   <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_v_q <= in_valid;
			end
			if (s1_go && last_s1) begin
				frame_v_s2 <= 1'b1;
			end else if (frame_take) begin
				frame_v_s2 <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_LINE_COUNT: line_count_q <= cfg_data;
					CFG_PATTERN:    pattern_q    <= pattern_t'(cfg_data[1:0]);
					default:        line_count_q <= line_count_q;
				endcase
				pos_q   <= '0;
				acc_l_q <= '0;
				acc_r_q <= '0;
			end else begin
				if (in_acc) begin
					pos_q <= in_last ? '0 : pos_q + POS_W'(1);
				end
				if (s1_go) begin
					acc_l_q <= last_s1 ? '0 : sum_l;
					acc_r_q <= last_s1 ? '0 : sum_r;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1  <= line_sample;
			weights_s1 <= weights;
			last_s1    <= in_last;
			recip_s1   <= recip_for(pattern_q, lines_m1);
		end
		if (s1_go && last_s1) begin
			frame_l_s2 <= sum_l;
			frame_r_s2 <= sum_r;
			recip_s2   <= recip_s1;
		end
	end

	rotm_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_v_s2),
		.frame_left  (frame_l_s2),
		.frame_right (frame_r_s2),
		.frame_recip (recip_s2),
		.frame_take  (frame_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.wet_left    (wet_left),
		.wet_right   (wet_right)
	);

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= lines_m1)
		else $error("line position beyond the frame");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> pos_q == '0)
		else $error("line position did not wrap after the last line");

	a_frame_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_v_s2) |-> $past(s1_v_q && last_s1))
		else $error("frame result without a last line");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_v_q && last_s1 && frame_v_s2)
		else $error("input stalled with room to accept an item");

endmodule

>>> design/rotm_norm.sv
// frame normalizer: reciprocal multiply, floor, saturation and output register
`timescale 1ns / 1ps

module rotm_norm
	import rotm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       frame_valid,
	input  logic signed [ACC_W-1:0]    frame_left,
	input  logic signed [ACC_W-1:0]    frame_right,
	input  logic [RECIP_W-1:0]         frame_recip,
	output logic                       frame_take,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] wet_left,
	output logic signed [SAMPLE_W-1:0] wet_right
);

	localparam int SHIFT_W = PROD_W - FRAC_W;

	function automatic logic signed [SAMPLE_W-1:0] floor_sat(logic signed [PROD_W-1:0] prod);
		logic signed [SHIFT_W-1:0] q;
		logic signed [SHIFT_W-1:0] hi;
		logic signed [SHIFT_W-1:0] lo;
		q  = SHIFT_W'(prod >>> FRAC_W);
		hi = SHIFT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
		lo = -SHIFT_W'(64'sd1 <<< (SAMPLE_W - 1));
		if (q > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (q < lo) begin
			return lo[SAMPLE_W-1:0];
		end
		return q[SAMPLE_W-1:0];
	endfunction

	logic                     prod_v_s3;
	logic signed [PROD_W-1:0] prod_l_s3;
	logic signed [PROD_W-1:0] prod_r_s3;
	logic                     out_v_q;
	logic signed [SAMPLE_W-1:0] wet_l_q;
	logic signed [SAMPLE_W-1:0] wet_r_q;
	logic signed [PROD_W-1:0] prod_l;
	logic signed [PROD_W-1:0] prod_r;
	logic                     out_free;
	logic                     prod_free;

	assign out_free   = !out_v_q || !out_stall;
	assign prod_free  = !prod_v_s3 || out_free;
	assign frame_take = prod_free;

	assign prod_l = frame_left * $signed({1'b0, frame_recip});
	assign prod_r = frame_right * $signed({1'b0, frame_recip});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s3 <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (prod_free) begin
				prod_v_s3 <= frame_valid;
			end
			if (out_free) begin
				out_v_q <= prod_v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_free && frame_valid) begin
			prod_l_s3 <= prod_l;
			prod_r_s3 <= prod_r;
		end
		if (out_free && prod_v_s3) begin
			wet_l_q <= floor_sat(prod_l_s3);
			wet_r_q <= floor_sat(prod_r_s3);
		end
	end

	assign out_valid = out_v_q;
	assign wet_left  = wet_l_q;
	assign wet_right = wet_r_q;

	a_prod_moves: assert property (@(posedge clk) disable iff (!arst_n)
		prod_v_s3 && out_free |=> out_v_q)
		else $error("product stage did not reach the output register");

	a_frame_lands: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && prod_free |=> prod_v_s3)
		else $error("taken frame did not reach the product stage");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(prod_v_s3))
		else $error("result appeared without a product");

endmodule
